/* hw/rtl/pba_pkg.sv */
// Shared constants, payload types and helpers of the page bitmap allocator.
`timescale 1ns / 1ps
package pba_pkg;

	localparam int ADDR_W     = 48;
	localparam int PAGE_SHIFT = 12;
	localparam int POOL_PAGES = 64;
	localparam int WORD_BITS  = 64;
	localparam int BIT_AW     = 6;
	localparam int WORD_COUNT = (POOL_PAGES + WORD_BITS - 1) / WORD_BITS;
	localparam int WORD_AW    = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
	localparam int PAGE_AW    = WORD_AW + BIT_AW;
	localparam int PAGE_NUM_W = ADDR_W - PAGE_SHIFT;
	localparam int TAIL_PAGES = POOL_PAGES % WORD_BITS;

	// bits of the last word that lie beyond the pool; they always read as used
	localparam logic [WORD_BITS-1:0] TAIL_PAD =
		(TAIL_PAGES == 0) ? '0 : ~((WORD_BITS'(1) << TAIL_PAGES) - WORD_BITS'(1));

	typedef enum logic {
		MODE_ALLOC = 1'b0,
		MODE_FREE  = 1'b1
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_EMPTY   = 2'd1,
		ST_BADFREE = 2'd2
	} status_t;

	typedef struct packed {
		mode_t              mode;
		logic [ADDR_W-1:0]  free_address;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  page_address;
		status_t            status;
	} rsp_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  pool_base;
	} cfg_t;

	typedef struct packed {
		logic               found;
		logic [BIT_AW-1:0]  idx;
	} ffz_t;

	// lowest clear bit of a bitmap word
	function automatic ffz_t first_zero(input logic [WORD_BITS-1:0] word);
		ffz_t r;
		r.found = 1'b0;
		r.idx   = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!word[i]) begin
				r.found = 1'b1;
				r.idx   = BIT_AW'(i);
			end
		end
		return r;
	endfunction

endpackage

/* hw/rtl/pba_chan_if.sv */
// Valid/ready channel carrying one payload of a given type.
`timescale 1ns / 1ps
interface pba_chan_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

/* hw/rtl/pba_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module pba_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hw/rtl/page_bitmap_allocator.sv */
// Page bitmap allocator: top level with bitmap RAM, request sequencer and result register.
// Allocate: IDLE issues the read of word 0, then EVAL scans the bitmap RAM one word per cycle with
// find-first-zero until a clear bit or the last word (words read: 1..WORD_COUNT), then EMIT; free goes
// through FCHK, EVAL and EMIT, straight from FCHK to EMIT when the address lies outside the pool.
// Throughput: one request at a time; EMIT waits while the result register holds an untaken result.
// Reset: per-word valid bits clear at once, so the whole bitmap reads free; no clearing pass.
`timescale 1ns / 1ps
module page_bitmap_allocator (
	input  logic        clk,
	input  logic        arst_n,
	pba_chan_if.sink    req,
	pba_chan_if.source  rsp,
	pba_chan_if.sink    cfg
);
	import pba_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_FCHK,
		S_EVAL,
		S_EMIT
	} state_t;

	state_t                 state_q;
	mode_t                  mode_q;
	logic [ADDR_W-1:0]      faddr_q;
	logic [ADDR_W-1:0]      base_q;
	logic [WORD_AW-1:0]     w_q;
	logic [BIT_AW-1:0]      bit_q;
	logic [WORD_COUNT-1:0]  word_valid_q;
	logic [ADDR_W-1:0]      res_addr_q;
	status_t                res_st_q;
	logic                   out_valid_q;
	logic [ADDR_W-1:0]      out_addr_q;
	status_t                out_st_q;

	logic                   req_fire;
	logic [ADDR_W-1:0]      base_al;
	logic [ADDR_W-1:0]      off;
	logic [PAGE_NUM_W-1:0]  off_page;
	logic                   in_range;
	logic [WORD_BITS-1:0]   rdata;
	logic [WORD_BITS-1:0]   word_eff;
	logic [WORD_BITS-1:0]   alloc_view;
	ffz_t                   ffz;
	logic                   last_word;
	logic [ADDR_W-1:0]      alloc_addr;
	logic                   out_free;

	logic                   ram_we;
	logic                   ram_re;
	logic [WORD_AW-1:0]     ram_raddr;
	logic [WORD_BITS-1:0]   ram_wdata;

	assign req.ready = (state_q == S_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	assign rsp.valid                = out_valid_q;
	assign rsp.payload.page_address = out_addr_q;
	assign rsp.payload.status       = out_st_q;
	assign out_free                 = !out_valid_q || rsp.ready;

	assign base_al  = {base_q[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
	assign off      = faddr_q - base_al;
	assign off_page = off[ADDR_W-1:PAGE_SHIFT];
	assign in_range = off_page < PAGE_NUM_W'(POOL_PAGES);

	// a word never written since reset reads as all free
	assign word_eff   = word_valid_q[w_q] ? rdata : '0;
	assign last_word  = (w_q == WORD_AW'(WORD_COUNT - 1));
	assign alloc_view = word_eff | (last_word ? TAIL_PAD : '0);
	assign ffz        = first_zero(alloc_view);
	assign alloc_addr = base_al + (ADDR_W'({w_q, ffz.idx}) << PAGE_SHIFT);

	// Writes happen only in EVAL, which then moves to EMIT, and reads are issued only in IDLE, FCHK or an
	// EVAL that does not write, so the RAM never sees a read racing a write of the same word.
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = w_q;
		ram_we    = 1'b0;
		ram_wdata = word_eff;
		unique case (state_q)
			S_IDLE: begin
				if (req_fire && req.payload.mode == MODE_ALLOC) begin
					ram_re    = 1'b1;
					ram_raddr = '0;
				end
			end
			S_FCHK: begin
				if (in_range) begin
					ram_re    = 1'b1;
					ram_raddr = off_page[PAGE_AW-1:BIT_AW];
				end
			end
			S_EVAL: begin
				if (mode_q == MODE_ALLOC) begin
					if (ffz.found) begin
						ram_we    = 1'b1;
						ram_wdata = word_eff | (WORD_BITS'(1) << ffz.idx);
					end else if (!last_word) begin
						ram_re    = 1'b1;
						ram_raddr = w_q + WORD_AW'(1);
					end
				end else if (word_eff[bit_q]) begin
					ram_we    = 1'b1;
					ram_wdata = word_eff & ~(WORD_BITS'(1) << bit_q);
				end
			end
			default: begin
			end
		endcase
	end

	pba_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (WORD_COUNT),
		.AW    (WORD_AW)
	) u_bitmap (
		.clk   (clk),
		.we    (ram_we),
		.waddr (w_q),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			base_q <= cfg.payload.pool_base;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			word_valid_q <= '0;
			out_valid_q  <= 1'b0;
			out_addr_q   <= '0;
			out_st_q     <= ST_OK;
			mode_q       <= MODE_ALLOC;
			faddr_q      <= '0;
			w_q          <= '0;
			bit_q        <= '0;
			res_addr_q   <= '0;
			res_st_q     <= ST_OK;
		end else begin
			if (ram_we) begin
				word_valid_q[w_q] <= 1'b1;
			end
			// result register: load from EMIT, else drop on the output transfer
			if (state_q == S_EMIT && out_free) begin
				out_valid_q <= 1'b1;
				out_addr_q  <= res_addr_q;
				out_st_q    <= res_st_q;
			end else if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						mode_q  <= req.payload.mode;
						faddr_q <= req.payload.free_address;
						w_q     <= '0;
						state_q <= (req.payload.mode == MODE_ALLOC) ? S_EVAL : S_FCHK;
					end
				end
				S_FCHK: begin
					w_q   <= off_page[PAGE_AW-1:BIT_AW];
					bit_q <= off_page[BIT_AW-1:0];
					if (in_range) begin
						state_q <= S_EVAL;
					end else begin
						res_addr_q <= '0;
						res_st_q   <= ST_BADFREE;
						state_q    <= S_EMIT;
					end
				end
				S_EVAL: begin
					if (mode_q == MODE_ALLOC) begin
						if (ffz.found) begin
							res_addr_q <= alloc_addr;
							res_st_q   <= ST_OK;
							state_q    <= S_EMIT;
						end else if (last_word) begin
							res_addr_q <= '0;
							res_st_q   <= ST_EMPTY;
							state_q    <= S_EMIT;
						end else begin
							w_q <= w_q + WORD_AW'(1);
						end
					end else begin
						res_addr_q <= '0;
						res_st_q   <= word_eff[bit_q] ? ST_OK : ST_BADFREE;
						state_q    <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_write_in_eval: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> state_q == S_EVAL)
		else $error("bitmap written outside EVAL");

	a_fire_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> state_q != S_IDLE)
		else $error("accepted request did not start");

	a_result_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_EMIT)
		else $error("result raised outside EMIT");

	a_fail_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_st_q != ST_OK |-> out_addr_q == '0)
		else $error("failed request returned a nonzero address");

	a_free_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EVAL && mode_q == MODE_FREE |=> res_addr_q == '0)
		else $error("free returned a nonzero address");

endmodule

/* sim/tb.sv */
// Self-checking testbench for the page bitmap allocator.
`timescale 1ns / 1ps
module tb;
	import pba_pkg::*;

	localparam logic [ADDR_W-1:0] ADDR_ONES = {ADDR_W{1'b1}};
	localparam int PAGE_BYTES = 1 << PAGE_SHIFT;

	logic clk;
	logic arst_n;

	pba_chan_if #(.T(req_t)) req_ch ();
	pba_chan_if #(.T(rsp_t)) rsp_ch ();
	pba_chan_if #(.T(cfg_t)) cfg_ch ();

	page_bitmap_allocator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// mirror of the allocator state
	logic [POOL_PAGES-1:0] used_map;
	logic [ADDR_W-1:0]     base_cfg;
	rsp_t                  rsp_due[$];

	int errors;
	int n_req, n_base, n_alloc_ok, n_full, n_free_ok, n_free_bad;
	bit no_idle;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("tb: timeout at %0t", $time);
		$display("tb: errors");
		$finish;
	end

	function automatic logic [ADDR_W-1:0] base_aligned();
		return {base_cfg[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
	endfunction

	// apply one request to the mirror and return the result it must produce
	function automatic rsp_t pool_predict(input req_t r);
		rsp_t o;
		logic [ADDR_W-1:0] off;
		logic [PAGE_NUM_W-1:0] pg;
		int pick;
		o.page_address = '0;
		pick = -1;
		if (r.mode == MODE_ALLOC) begin
			for (int i = POOL_PAGES - 1; i >= 0; i--)
				if (!used_map[i]) pick = i;
			if (pick < 0) begin
				o.status = ST_EMPTY;
				n_full++;
			end else begin
				used_map[pick] = 1'b1;
				o.page_address = base_aligned() + (ADDR_W'(pick) << PAGE_SHIFT);
				o.status = ST_OK;
				n_alloc_ok++;
			end
		end else begin
			off = r.free_address - base_aligned();
			pg = off[ADDR_W-1:PAGE_SHIFT];
			if (pg >= POOL_PAGES || !used_map[pg]) begin
				o.status = ST_BADFREE;
				n_free_bad++;
			end else begin
				used_map[pg] = 1'b0;
				o.status = ST_OK;
				n_free_ok++;
			end
		end
		return o;
	endfunction

	function automatic int pick_gap();
		int r;
		if (no_idle) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [ADDR_W-1:0] rand_addr();
		return {16'($urandom), 32'($urandom)};
	endfunction

	// a random page that is currently allocated, or -1
	function automatic int pick_used();
		int cnt, k;
		cnt = 0;
		for (int i = 0; i < POOL_PAGES; i++) cnt += used_map[i];
		if (cnt == 0) return -1;
		k = $urandom_range(0, cnt - 1);
		for (int i = 0; i < POOL_PAGES; i++)
			if (used_map[i]) begin
				if (k == 0) return i;
				k--;
			end
		return -1;
	endfunction

	function automatic logic [ADDR_W-1:0] page_addr(input int pg, input logic [11:0] ofs);
		return base_aligned() + (ADDR_W'(pg) << PAGE_SHIFT) + ADDR_W'(ofs);
	endfunction

	// valid stays high on return; the next call either reuses it or lowers it first
	task automatic send_req(input mode_t m, input logic [ADDR_W-1:0] a);
		req_t r;
		int gap;
		r.mode = m;
		r.free_address = a;
		gap = pick_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid   <= 1'b1;
		req_ch.payload <= r;
		do @(posedge clk); while (!req_ch.ready);
		rsp_due.push_back(pool_predict(r));
		n_req++;
	endtask

	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		while (rsp_due.size() != 0) @(posedge clk);
	endtask

	task automatic set_base(input logic [ADDR_W-1:0] v);
		cfg_t c;
		c.pool_base = v;
		wait_drained();
		cfg_ch.valid   <= 1'b1;
		cfg_ch.payload <= c;
		do @(posedge clk); while (!cfg_ch.ready);
		base_cfg = v;
		n_base++;
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// result side: random backpressure and in-order compare
	initial begin
		int stall;
		rsp_t exp_r;
		stall = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
				if (rsp_due.size() == 0) begin
					$display("%0t: unexpected result addr=%h status=%0d", $time,
						rsp_ch.payload.page_address, rsp_ch.payload.status);
					errors++;
				end else begin
					exp_r = rsp_due.pop_front();
					if (rsp_ch.payload.page_address !== exp_r.page_address) begin
						$display("%0t: page_address expected %h actual %h", $time,
							exp_r.page_address, rsp_ch.payload.page_address);
						errors++;
					end
					if (rsp_ch.payload.status !== exp_r.status) begin
						$display("%0t: status expected %0d actual %0d", $time,
							exp_r.status, rsp_ch.payload.status);
						errors++;
					end
				end
			end
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				stall--;
			end else begin
				rsp_ch.ready <= 1'b1;
				if ($urandom_range(0, 3) == 0) stall = pick_gap();
			end
		end
	end

	task automatic test_directed();
		logic [ADDR_W-1:0] a;
		// base zero: page zero comes back as address 0 with an ok status
		send_req(MODE_ALLOC, ADDR_ONES);
		send_req(MODE_ALLOC, '0);
		send_req(MODE_FREE, ADDR_W'(12'hFFF));     // offset inside page ignored
		send_req(MODE_FREE, ADDR_W'(12'hFFF));     // already free
		send_req(MODE_FREE, ADDR_W'(POOL_PAGES * PAGE_BYTES));
		send_req(MODE_FREE, ADDR_W'(POOL_PAGES * PAGE_BYTES - 1)); // last page, not used
		send_req(MODE_FREE, ADDR_ONES);
		send_req(MODE_ALLOC, '0);
		// unaligned base, low bits dropped
		set_base(48'h0000_1234_5FFF);
		send_req(MODE_ALLOC, '0);
		send_req(MODE_FREE, base_aligned() - 1);
		send_req(MODE_FREE, page_addr(POOL_PAGES - 1, 12'hABC));
		send_req(MODE_FREE, page_addr(2, 12'h000));
		// top of the address space: allocations wrap past 2^48
		set_base(ADDR_ONES);
		send_req(MODE_ALLOC, '0);
		send_req(MODE_ALLOC, '0);
		a = page_addr(3, 12'hFFF);
		send_req(MODE_FREE, a);
		send_req(MODE_FREE, ADDR_W'(12'h123));     // wraps to page 1
		send_req(MODE_FREE, ADDR_ONES);            // page 0
		send_req(MODE_FREE, '0);
	endtask

	task automatic test_exhaust();
		int pg;
		set_base({16'($urandom), 20'($urandom), 12'h000});
		repeat (POOL_PAGES + 3) send_req(MODE_ALLOC, rand_addr());
		no_idle = 1'b1;
		repeat (4) send_req(MODE_ALLOC, '0);
		no_idle = 1'b0;
		for (int i = 0; i < POOL_PAGES; i++) begin
			pg = pick_used();
			if (pg >= 0) send_req(MODE_FREE, page_addr(pg, 12'($urandom)));
			if ($urandom_range(0, 7) == 0)
				send_req(MODE_FREE, page_addr($urandom_range(0, POOL_PAGES - 1),
					12'($urandom)));
		end
	endtask

	task automatic random_phase(input logic [ADDR_W-1:0] b, input int n_items,
			input int alloc_pct, input bit quiet);
		int r, pg;
		set_base(b);
		no_idle = quiet;
		repeat (n_items) begin
			r = $urandom_range(0, 99);
			pg = pick_used();
			if (r < alloc_pct) begin
				send_req(MODE_ALLOC, rand_addr());
			end else if (r < alloc_pct + 25 && pg >= 0) begin
				send_req(MODE_FREE, page_addr(pg, 12'($urandom)));
			end else begin
				case ($urandom_range(0, 2))
					0: send_req(MODE_FREE, rand_addr());
					1: send_req(MODE_FREE, page_addr($urandom_range(0, POOL_PAGES + 2),
						12'($urandom)));
					default: send_req(MODE_FREE,
						base_aligned() - ADDR_W'($urandom_range(1, 3 * PAGE_BYTES)));
				endcase
			end
		end
		no_idle = 1'b0;
	endtask

	task automatic test_random();
		random_phase('0, 80, 60, 1'b0);
		random_phase(ADDR_ONES, 80, 70, 1'b0);
		random_phase(rand_addr(), 80, 45, 1'b1);
		random_phase({28'hFFF_FFFF, 8'($urandom), 12'h000}, 80, 75, 1'b0);
		random_phase(rand_addr(), 80, 50, 1'b0);
	endtask

	initial begin
		errors = 0;
		n_req = 0; n_base = 0;
		n_alloc_ok = 0; n_full = 0; n_free_ok = 0; n_free_bad = 0;
		no_idle = 1'b0;
		used_map = '0;
		base_cfg = '0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.payload = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.payload = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_exhaust();
		test_random();

		wait_drained();
		repeat (10) @(posedge clk);
		$display("tb: %0d requests over %0d base settings", n_req, n_base);
		$display("tb: allocs ok %0d, pool full %0d, frees ok %0d, rejected frees %0d",
			n_alloc_ok, n_full, n_free_ok, n_free_bad);
		if (errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

/* files.f */
hw/rtl/pba_pkg.sv
hw/rtl/pba_chan_if.sv
hw/rtl/pba_ram.sv
hw/rtl/page_bitmap_allocator.sv
sim/tb.sv
